/* sv/ssrch_pkg.sv */
// Shared types, constants and the byte folding function for the substring search block.
// No dependencies; every other file of the block imports this package.
package ssrch_pkg;

    // Defaults for the top level parameters
    localparam int NEEDLE_MAX_DEF = 16;
    localparam int POS_WIDTH_DEF  = 32;

    // Fixed geometry of the register file and the result field
    localparam int NEEDLE_BYTES = 16;
    localparam int LEN_W        = 5;
    localparam int POSITION_W   = 32;
    localparam int OFFSET_W     = 32;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 3;

    // Character codes used by the folding rules
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;   // 'a'
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;   // 'z'
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;   // 'A'
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;   // '/'
    localparam logic [7:0] CHAR_BSLASH  = 8'h5C;   // backslash
    localparam logic [7:0] CASE_DELTA   = CHAR_LOWER_A - CHAR_UPPER_A;

    // Match flag bits
    localparam int FLAG_CASE  = 0;
    localparam int FLAG_SLASH = 1;

    // Input command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_NEEDLE_LOW    = 3'd0,
        REG_NEEDLE_HIGH   = 3'd1,
        REG_NEEDLE_LENGTH = 3'd2,
        REG_MATCH_FLAGS   = 3'd3,
        REG_START_OFFSET  = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } haystack_item_t;

    typedef struct packed {
        logic                  found;
        logic [POSITION_W-1:0] position;
    } result_item_t;

    // Control broadcast from the top level to every cell
    typedef struct packed {
        logic       shift;
        logic       clear;
        logic [1:0] flags;
    } ssrch_ctrl_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic [1:0] flags);
        logic [7:0] r;
        r = c;
        if (flags[FLAG_CASE] && (c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z))
            r = c - CASE_DELTA;
        if (flags[FLAG_SLASH] && (c == CHAR_BSLASH))
            r = CHAR_SLASH;
        return r;
    endfunction

endpackage

/* sv/ssrch_cell.sv */
// One cell of the match chain: compares the folded haystack byte with one needle byte.
// Depends on ssrch_pkg for the control struct and the folding function.
module ssrch_cell
    import ssrch_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ssrch_ctrl_t ctrl,
    input  logic [7:0]  hay_byte,     // already folded
    input  logic [7:0]  needle_byte,  // raw, folded here
    input  logic        prev_match,   // neighbor's partial match from the previous byte
    output logic        match_next,
    output logic        match
);

    logic match_reg;

    // Needle prefix up to this cell ends at the current byte
    assign match_next = prev_match && (hay_byte == fold_byte(needle_byte, ctrl.flags));
    assign match      = match_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            match_reg <= match_next;
        end
    end

endmodule

/* sv/substring_search_core.sv */
// Top level of the streaming substring search block: config registers, cell row, result register.
// Depends on ssrch_pkg and ssrch_cell.
//
// The block scans a haystack one byte per item and reports, on an end item, whether the
// configured needle (up to 16 bytes, optional case and slash folding on both sides) occurs
// at or after start_offset, with the first match position or else the haystack length.
// The row of match cells advances once per accepted byte, so a new item may be accepted on
// every cycle unless an end item is held. The result appears in the output register on the
// cycle after the end item is accepted and the input keeps flowing while it waits, unless a
// second end item arrives before the first result is taken. An empty needle matches at
// start_offset when start_offset does not exceed the length. The byte counter saturates at
// 2^POS_WIDTH - 1; bytes beyond that are dropped. The config port always accepts writes;
// indexes past the register list are ignored. Write the needle and the flags between
// haystacks only: the cells carry partial matches from byte to byte. There is no clearing
// pass after reset.
module substring_search_core
    import ssrch_pkg::*;
#(
    parameter int NEEDLE_MAX = NEEDLE_MAX_DEF,
    parameter int POS_WIDTH  = POS_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // haystack channel
    input  logic                   haystack_valid,
    output logic                   haystack_ready,
    input  haystack_item_t         haystack,
    // result channel
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_item_t           result,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CELLS = (NEEDLE_MAX < NEEDLE_BYTES) ? NEEDLE_MAX : NEEDLE_BYTES;
    localparam int CMP_W = ((POS_WIDTH > OFFSET_W) ? POS_WIDTH : OFFSET_W) + 1;

    // Configuration registers
    logic [CFG_DATA_W-1:0] needle_low_reg;
    logic [CFG_DATA_W-1:0] needle_high_reg;
    logic [LEN_W-1:0]      needle_length_reg;
    logic [1:0]            match_flags_reg;
    logic [OFFSET_W-1:0]   start_offset_reg;

    // Stream state
    logic [POS_WIDTH-1:0]  count_reg, count_next;
    logic                  seen_reg, seen_next;
    logic [POS_WIDTH-1:0]  mpos_reg, mpos_next;

    // Output register
    logic                  result_valid_reg, result_valid_next;
    result_item_t          result_reg, result_next;

    logic                  hay_fire, byte_take, end_take, drop;
    logic [LEN_W-1:0]      nlen;
    logic [7:0]            hay_folded;
    ssrch_ctrl_t           ctrl;
    logic [CELLS-1:0]      cell_match, cell_next, cell_sel;
    logic                  chain_hit, hit;
    logic [CMP_W-1:0]      start_ext, count_ext, match_start;

    // Hold an end item only while a finished result waits and is not being taken;
    // bytes keep flowing
    assign haystack_ready = !result_valid_reg || result_ready || (haystack.cmd == CMD_BYTE);
    assign hay_fire       = haystack_valid && haystack_ready;
    assign drop           = &count_reg;
    assign byte_take      = hay_fire && (haystack.cmd == CMD_BYTE) && !drop;
    assign end_take       = hay_fire && (haystack.cmd == CMD_END);

    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Clamp the needle length to the number of cells
    always_comb
    begin
        if (needle_length_reg > LEN_W'(CELLS))
            nlen = LEN_W'(CELLS);
        else
            nlen = needle_length_reg;
    end

    assign hay_folded = fold_byte(haystack.data_byte, match_flags_reg);
    assign ctrl.shift = byte_take;
    assign ctrl.clear = end_take;
    assign ctrl.flags = match_flags_reg;

    // Row of cells; cell k holds "needle bytes 0..k end at the last byte"
    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        logic [7:0] nbyte;
        logic       prev;

        if (k < 8)
        begin : g_low
            assign nbyte = needle_low_reg[8*k +: 8];
        end
        else
        begin : g_high
            assign nbyte = needle_high_reg[8*(k-8) +: 8];
        end

        if (k == 0)
        begin : g_head
            assign prev = 1'b1;
        end
        else
        begin : g_link
            assign prev = cell_match[k-1];
        end

        assign cell_sel[k] = (nlen == LEN_W'(k + 1));

        ssrch_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .hay_byte    (hay_folded),
            .needle_byte (nbyte),
            .prev_match  (prev),
            .match_next  (cell_next[k]),
            .match       (cell_match[k])
        );
    end

    // Full needle ends at this byte when the last active cell matches
    assign chain_hit = |(cell_next & cell_sel);

    // Match start = count + 1 - n, compared against the start offset
    assign start_ext   = CMP_W'(start_offset_reg);
    assign count_ext   = CMP_W'(count_reg);
    assign match_start = count_ext + CMP_W'(1) - CMP_W'(nlen);
    assign hit         = byte_take && !seen_reg && (nlen != '0) && chain_hit
                         && (match_start >= start_ext);

    always_comb
    begin
        count_next        = count_reg;
        seen_next         = seen_reg;
        mpos_next         = mpos_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        if (result_valid_reg && result_ready)
            result_valid_next = 1'b0;

        if (byte_take)
        begin
            count_next = count_reg + POS_WIDTH'(1);
            if (hit)
            begin
                seen_next = 1'b1;
                mpos_next = POS_WIDTH'(match_start);
            end
        end

        if (end_take)
        begin
            result_valid_next = 1'b1;
            if (nlen == '0)
            begin
                // Empty needle: match at the start offset if it lies within the haystack
                if (start_ext <= count_ext)
                begin
                    result_next.found    = 1'b1;
                    result_next.position = POSITION_W'(start_offset_reg);
                end
                else
                begin
                    result_next.found    = 1'b0;
                    result_next.position = POSITION_W'(count_reg);
                end
            end
            else
            begin
                result_next.found    = seen_reg;
                result_next.position = seen_reg ? POSITION_W'(mpos_reg) : POSITION_W'(count_reg);
            end
            // Drop the stream state for the next haystack
            count_next = '0;
            seen_next  = 1'b0;
            mpos_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            seen_reg         <= 1'b0;
            mpos_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            seen_reg         <= seen_next;
            mpos_reg         <= mpos_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_low_reg    <= '0;
            needle_high_reg   <= '0;
            needle_length_reg <= '0;
            match_flags_reg   <= '0;
            start_offset_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_index_t'(cfg_index))
                REG_NEEDLE_LOW:    needle_low_reg    <= cfg_data;
                REG_NEEDLE_HIGH:   needle_high_reg   <= cfg_data;
                REG_NEEDLE_LENGTH: needle_length_reg <= cfg_data[LEN_W-1:0];
                REG_MATCH_FLAGS:   match_flags_reg   <= cfg_data[1:0];
                REG_START_OFFSET:  start_offset_reg  <= cfg_data[OFFSET_W-1:0];
                default:           ;
            endcase
        end
    end

    // A recorded match start always lies before the current byte count
    assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> (mpos_reg < count_reg))
        else $error("match position not below byte count");

    // An end item clears the stream and loads the result
    assert property (@(posedge clk) disable iff (!rst_n)
        end_take |=> (count_reg == '0) && !seen_reg && result_valid_reg)
        else $error("end item did not clear stream or load result");

    // Each counted byte advances the counter by one
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_take |=> (count_reg == $past(count_reg) + POS_WIDTH'(1)))
        else $error("byte counter did not advance");

    // A match is recorded only on an accepted byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(seen_reg) |-> $past(byte_take))
        else $error("match recorded without a byte");

endmodule
